@@ rtl/ylr_pkg.sv @@
// Shared types and constants of the YUV420 semi-planar line rasterizer.
// Used by the register block, the controller, the datapath and the top level.
package ylr_pkg;

  // Default coordinate width
  localparam int unsigned COORD_BITS_DEF = 12;

  // Fixed field widths
  localparam int unsigned DIM_W      = 12;
  localparam int unsigned STRIDE_W   = 13;
  localparam int unsigned OFF_W      = 25;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  // Result stream: valid, luma offset, luma pair, chroma offset, chroma next row
  localparam int unsigned OUT_FIELDS_W = 2 * OFF_W + 3;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LUMA_STRIDE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_LUMA     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_CB       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DRAW_CR       = 3'd6;

  // Register reset values
  localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH   = 12'd1920;
  localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT  = 12'd1080;
  localparam logic [STRIDE_W-1:0] RST_LUMA_STRIDE   = 13'd1920;
  localparam logic [STRIDE_W-1:0] RST_CHROMA_STRIDE = 13'd1920;

  // Input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // Addressing configuration seen by the datapath
  typedef struct packed {
    logic [DIM_W-1:0]    image_width;
    logic [DIM_W-1:0]    image_height;
    logic [STRIDE_W-1:0] luma_stride;
    logic [STRIDE_W-1:0] chroma_stride;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;     // capture a new segment
    logic step;     // produce one result
    logic walking;  // a segment is active
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic at_end;   // walk position sits on the segment end
  } stat_t;

endpackage

@@ rtl/ylr_cfg_regs.sv @@
// Configuration register file of the line rasterizer.
// Depends on ylr_pkg for register indexes, reset values and cfg_t.
module ylr_cfg_regs import ylr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  // Register writes; drawing bytes are applied by the pixel writer, not here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.image_width   <= RST_IMAGE_WIDTH;
      cfg_q.image_height  <= RST_IMAGE_HEIGHT;
      cfg_q.luma_stride   <= RST_LUMA_STRIDE;
      cfg_q.chroma_stride <= RST_CHROMA_STRIDE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i) inside
        REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data_i[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data_i[DIM_W-1:0];
        REG_LUMA_STRIDE:   cfg_q.luma_stride   <= cfg_data_i[STRIDE_W-1:0];
        REG_CHROMA_STRIDE: cfg_q.chroma_stride <= cfg_data_i[STRIDE_W-1:0];
        REG_DRAW_LUMA, REG_DRAW_CB, REG_DRAW_CR: ;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/ylr_ctrl.sv @@
// Controller of the line rasterizer: segment state and output handshake.
// Depends on ylr_pkg for cmd_t, stat_t and the item kinds.
module ylr_ctrl import ylr_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  logic  in_kind_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  // Output register empty or draining this cycle
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign cmd_o.load    = accept && (in_kind_i == KIND_LOAD);
  assign cmd_o.step    = accept && (in_kind_i == KIND_STEP);
  assign cmd_o.walking = (state_q == ST_WALK);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_o.load) state_d = ST_WALK;
      end
      ST_WALK: begin
        if (cmd_o.step && stat_i.at_end) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result pending flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.step)       out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/ylr_datapath.sv @@
// Datapath of the line rasterizer: segment setup, incremental DDA, address
// generation and the result register. Depends on ylr_pkg.
module ylr_datapath import ylr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                         clk_i,
  input  cmd_t                                         cmd_i,
  input  cfg_t                                         cfg_i,
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]            in_tdata_i,
  output stat_t                                        stat_o,
  output logic [OUT_TDATA_W-1:0]                       res_tdata_o,
  output logic                                         res_tlast_o
);

  localparam int unsigned CB   = COORD_BITS;
  localparam int unsigned CMPW = (CB > DIM_W) ? CB : DIM_W;
  // Product width covers both the full product and the offset field
  localparam int unsigned PW   = (STRIDE_W + CB > OFF_W) ? STRIDE_W + CB : OFF_W;

  // Endpoint fields
  logic [CB-1:0] ax, ay, bx, by;
  assign ax = in_tdata_i[CB-1:0];
  assign ay = in_tdata_i[2*CB-1:CB];
  assign bx = in_tdata_i[3*CB-1:2*CB];
  assign by = in_tdata_i[4*CB-1:3*CB];

  // Segment setup
  logic signed [CB:0]   dx, dy, steep_frac;
  logic [CB:0]          adx_w, ady_w;
  logic [CB-1:0]        adx, ady, sx, ex, ymin, ymax, flat_frac;
  logic [CB+1:0]        three_adx;
  logic                 steep, a_first, ge1, ge2;
  logic [1:0]           flat_inc;

  always_comb begin
    dx        = $signed({1'b0, ax}) - $signed({1'b0, bx});
    dy        = $signed({1'b0, ay}) - $signed({1'b0, by});
    adx_w     = dx[CB] ? $unsigned(-dx) : $unsigned(dx);
    ady_w     = dy[CB] ? $unsigned(-dy) : $unsigned(dy);
    adx       = adx_w[CB-1:0];
    ady       = ady_w[CB-1:0];
    three_adx = {2'b00, adx} + {1'b0, adx, 1'b0};
    steep     = (adx == '0) || ({2'b00, ady} >= three_adx);
    // Walk starts at the endpoint of smaller y; ties start at B
    a_first   = ay < by;
    sx        = a_first ? ax : bx;
    ex        = a_first ? bx : ax;
    ymin      = a_first ? ay : by;
    ymax      = a_first ? by : ay;
    // Flat slope |dy|/|dx| is below 3: integer part by compare and subtract
    ge2       = {1'b0, ady} >= {adx, 1'b0};
    ge1       = ady >= adx;
    if (ge2) begin
      flat_inc  = 2'd2;
      flat_frac = ady - {adx[CB-2:0], 1'b0};
    end else if (ge1) begin
      flat_inc  = 2'd1;
      flat_frac = ady - adx;
    end else begin
      flat_inc  = 2'd0;
      flat_frac = ady;
    end
    steep_frac = $signed({1'b0, ex}) - $signed({1'b0, sx});
  end

  // Walk state: major axis position, minor coordinate as quotient/remainder
  logic [CB-1:0]      walk_q, walk_d, endp_q, endp_d, minor_q, minor_d;
  logic [CB-1:0]      rem_q, rem_d, den_q, den_d;
  logic [1:0]         inc_q, inc_d;
  logic signed [CB:0] frac_q, frac_d;
  logic               steep_q, steep_d, down_q, down_d;

  logic signed [CB+1:0] rem_sum, den_s, rem_next;
  logic [CB-1:0]        minor_inc, minor_next;
  logic                 at_end;

  assign at_end        = (walk_q == endp_q);
  assign stat_o.at_end = at_end;

  // One DDA step: add the fractional slope, correct once
  always_comb begin
    rem_sum   = $signed({2'b00, rem_q}) + $signed({frac_q[CB], frac_q});
    den_s     = $signed({2'b00, den_q});
    minor_inc = minor_q + CB'(inc_q);
    if (rem_sum >= den_s) begin
      rem_next   = rem_sum - den_s;
      minor_next = minor_inc + CB'(1);
    end else if (rem_sum < 0) begin
      rem_next   = rem_sum + den_s;
      minor_next = minor_inc - CB'(1);
    end else begin
      rem_next   = rem_sum;
      minor_next = minor_inc;
    end
  end

  // Next walk state
  always_comb begin
    walk_d  = walk_q;
    endp_d  = endp_q;
    minor_d = minor_q;
    rem_d   = rem_q;
    den_d   = den_q;
    inc_d   = inc_q;
    frac_d  = frac_q;
    steep_d = steep_q;
    down_d  = down_q;
    if (cmd_i.load) begin
      steep_d = steep;
      down_d  = !steep && (sx > ex);
      walk_d  = steep ? ymin : sx;
      endp_d  = steep ? ymax : ex;
      minor_d = steep ? sx : ymin;
      rem_d   = '0;
      // A single-point segment gets a unit denominator
      den_d   = steep ? ((ady == '0) ? CB'(1) : ady) : adx;
      inc_d   = steep ? 2'd0 : flat_inc;
      frac_d  = steep ? steep_frac : $signed({1'b0, flat_frac});
    end else if (cmd_i.step && cmd_i.walking && !at_end) begin
      walk_d  = down_q ? (walk_q - CB'(1)) : (walk_q + CB'(1));
      minor_d = minor_next;
      rem_d   = rem_next[CB-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q  <= walk_d;
    endp_q  <= endp_d;
    minor_q <= minor_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    inc_q   <= inc_d;
    frac_q  <= frac_d;
    steep_q <= steep_d;
    down_q  <= down_d;
  end

  // Pixel coordinates and bounds
  logic [CB-1:0]    x, y, y_half;
  logic [CMPW-1:0]  x_c, y_c, w_c, h_c;
  logic [CMPW:0]    x_p1, w_p;
  logic             x_in, y_in, x_pair, valid, pair;

  always_comb begin
    x      = steep_q ? minor_q : walk_q;
    y      = steep_q ? walk_q : minor_q;
    y_half = y >> 1;
    x_c    = CMPW'(x);
    y_c    = CMPW'(y);
    w_c    = CMPW'(cfg_i.image_width);
    h_c    = CMPW'(cfg_i.image_height);
    x_p1   = (CMPW+1)'(x) + (CMPW+1)'(1);
    w_p    = (CMPW+1)'(cfg_i.image_width);
    x_in   = x_c < w_c;
    y_in   = y_c < h_c;
    x_pair = x_p1 < w_p;
    valid  = steep_q ? y_in : (x_in && y_in);
    pair   = steep_q && y_in && x_pair;
  end

  // Plane offsets
  logic [PW-1:0]    luma_prod, chroma_prod;
  logic [OFF_W-1:0] luma_off, chroma_off;

  always_comb begin
    luma_prod   = PW'(cfg_i.luma_stride) * PW'(y);
    chroma_prod = PW'(cfg_i.chroma_stride) * PW'(y_half);
    luma_off    = valid ? (luma_prod[OFF_W-1:0] + OFF_W'(x)) : '0;
    chroma_off  = valid ? (chroma_prod[OFF_W-1:0] + OFF_W'({x[CB-1:1], 1'b0})) : '0;
  end

  // Result register; an idle step reports an invalid final write
  logic [OUT_TDATA_W-1:0] res_tdata_q;
  logic                   res_tlast_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      if (cmd_i.walking) begin
        res_tdata_q <= {{(OUT_TDATA_W-OUT_FIELDS_W){1'b0}},
                        pair, chroma_off, pair, luma_off, valid};
        res_tlast_q <= at_end;
      end else begin
        res_tdata_q <= '0;
        res_tlast_q <= 1'b1;
      end
    end
  end

  assign res_tdata_o = res_tdata_q;
  assign res_tlast_o = res_tlast_q;

endmodule

@@ rtl/yuv420sp_line_rasterizer_unit.sv @@
// Top level of the YUV420 semi-planar line rasterizer.
// Depends on ylr_pkg, ylr_cfg_regs, ylr_ctrl and ylr_datapath.
//
// A kind 0 transaction loads a segment and gives no result; each kind 1
// transaction gives one pixel write of that segment (luma and chroma byte
// offsets plus pair flags), tlast marking the final pixel, or an invalid write
// with tlast set when no segment is active. The block takes one transaction
// per clock unless the result side stalls: the minor coordinate is carried
// as a quotient and remainder that one add and one compare advance each step,
// and a single output register holds the result while tready passes straight
// back to the input, so a new item is taken in the cycle the previous result
// leaves. Each result is registered. There is no clearing pass after reset.
module yuv420sp_line_rasterizer_unit import ylr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Configuration writes
  input  logic                                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0]                 cfg_index_i,
  input  logic [CFG_DATA_W-1:0]                cfg_data_i,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // point_a_x, point_a_y, point_b_x, point_b_y, zero fill
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // kind
  input  logic                                 s_axis_tuser,
  // Result stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // write_valid, luma_offset, luma_pair, chroma_offset, chroma_next_row, zero fill
  output logic [OUT_TDATA_W-1:0]               m_axis_tdata,
  output logic                                 m_axis_tlast
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;

  ylr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ylr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_kind_i   (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  ylr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .cfg_i       (cfg),
    .in_tdata_i  (s_axis_tdata),
    .stat_o      (stat),
    .res_tdata_o (m_axis_tdata),
    .res_tlast_o (m_axis_tlast)
  );

endmodule

@@ bench/tb_yuv420sp_line_rasterizer_unit.sv @@
`timescale 1ns / 1ps
// Self-checking bench for yuv420sp_line_rasterizer_unit: drives segment loads and pixel steps
// on the input stream and scores every pixel write. Needs ylr_pkg and the rasterizer RTL.
module tb_yuv420sp_line_rasterizer_unit;
  import ylr_pkg::*;

  localparam int unsigned IN_TDATA_W = ((4 * COORD_BITS_DEF + 7) / 8) * 8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int unsigned COORD_MAX = (1 << COORD_BITS_DEF) - 1;

  // Tracks the segment walk and holds the pixel writes still owed by the block
  class pixel_write_board;
    typedef struct {
      bit        valid;
      bit [24:0] luma_off;
      bit        pair;
      bit [24:0] chroma_off;
      bit        next_row;
      bit        last;
    } pixel_write_t;

    pixel_write_t        pending_writes[$];
    logic [DIM_W-1:0]    img_w, img_h;
    logic [STRIDE_W-1:0] luma_stride, chroma_stride;
    logic [7:0]          luma_byte, cb_byte, cr_byte;
    logic [11:0]         a_x, a_y, b_x, b_y, walk_pos;
    bit                  steep, walk_down, active;
    int                  errors, loads, results, inside_writes;

    function new();
      img_w = RST_IMAGE_WIDTH;
      img_h = RST_IMAGE_HEIGHT;
      luma_stride = RST_LUMA_STRIDE;
      chroma_stride = RST_CHROMA_STRIDE;
      luma_byte = 8'd76;
      cb_byte = 8'd84;
      cr_byte = 8'd255;
      {a_x, a_y, b_x, b_y, walk_pos} = '0;
      {steep, walk_down, active} = '0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:   img_w = val[DIM_W-1:0];
        REG_IMAGE_HEIGHT:  img_h = val[DIM_W-1:0];
        REG_LUMA_STRIDE:   luma_stride = val;
        REG_CHROMA_STRIDE: chroma_stride = val;
        REG_DRAW_LUMA:     luma_byte = val[7:0];
        REG_DRAW_CB:       cb_byte = val[7:0];
        REG_DRAW_CR:       cr_byte = val[7:0];
        default: ;
      endcase
    endfunction

    // floor(p0 + (t - t0) * num / den), den nonzero
    function longint floor_line(longint t, longint t0, longint p0, longint num, longint den);
      longint n;
      if (den < 0) begin
        den = -den;
        num = -num;
      end
      n = p0 * den + (t - t0) * num;
      return (n >= 0) ? n / den : -((-n + den - 1) / den);
    endfunction

    // Called for every accepted input transaction
    function void note_item(logic kind, logic [IN_TDATA_W-1:0] data);
      pixel_write_t w;
      longint ax, ay, bx, by, adx, ady, x, y, endp, loff, coff;
      logic [11:0] sx, ex;
      if (kind == KIND_LOAD) begin
        a_x = data[11:0];
        a_y = data[23:12];
        b_x = data[35:24];
        b_y = data[47:36];
        adx = longint'(a_x) - longint'(b_x);
        ady = longint'(a_y) - longint'(b_y);
        if (adx < 0) adx = -adx;
        if (ady < 0) ady = -ady;
        steep = (adx == 0) || (ady >= 3 * adx);
        if (steep) begin
          walk_down = 1'b0;
          walk_pos = (a_y < b_y) ? a_y : b_y;
        end else begin
          // flat walk starts at the lower-y end, B on a tie
          sx = (a_y < b_y) ? a_x : b_x;
          ex = (a_y < b_y) ? b_x : a_x;
          walk_down = sx > ex;
          walk_pos = sx;
        end
        active = 1'b1;
        loads++;
        return;
      end
      w = '{default: 0};
      results++;
      if (!active) begin
        w.last = 1'b1;
        pending_writes.push_back(w);
        return;
      end
      ax = longint'(a_x);
      ay = longint'(a_y);
      bx = longint'(b_x);
      by = longint'(b_y);
      if (steep) begin
        y = longint'(walk_pos);
        x = (ax == bx) ? ax : floor_line(y, ay, ax, ax - bx, ay - by);
        endp = (ay > by) ? ay : by;
        if (y < longint'(img_h)) begin
          w.valid = 1'b1;
          w.pair = (x >= 0) && (x < longint'(img_w) - 1);
        end
      end else begin
        x = longint'(walk_pos);
        y = floor_line(x, ax, ay, ay - by, ax - bx);
        endp = (ay < by) ? bx : ax;
        w.valid = (x >= 0) && (x < longint'(img_w)) && (y >= 0) && (y < longint'(img_h));
      end
      if (w.valid) begin
        loff = longint'(luma_stride) * y + x;
        coff = longint'(chroma_stride) * (y / 2) + (x & ~longint'(1));
        w.luma_off = 25'(loff);
        w.chroma_off = 25'(coff);
        inside_writes++;
      end
      w.next_row = w.pair;
      w.last = (longint'(walk_pos) == endp);
      if (w.last) active = 1'b0;
      else if (walk_down) walk_pos = walk_pos - 12'd1;
      else walk_pos = walk_pos + 12'd1;
      pending_writes.push_back(w);
    endfunction

    function int field_diff(string name, longint unsigned exp_v, longint unsigned act_v);
      if (exp_v == act_v) return 0;
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      return 1;
    endfunction

    // Called for every accepted result transaction
    function void check_write(logic [OUT_TDATA_W-1:0] d, logic lst);
      pixel_write_t w;
      if (pending_writes.size() == 0) begin
        $error("pixel write with nothing outstanding: tdata=%h tlast=%b", d, lst);
        errors++;
        return;
      end
      w = pending_writes.pop_front();
      errors += field_diff("write_valid", w.valid, d[0]);
      errors += field_diff("luma_offset", w.luma_off, d[25:1]);
      errors += field_diff("luma_pair", w.pair, d[26]);
      errors += field_diff("chroma_offset", w.chroma_off, d[51:27]);
      errors += field_diff("chroma_next_row", w.next_row, d[52]);
      errors += field_diff("last", w.last, lst);
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // point_a_x, point_a_y, point_b_x, point_b_y
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  // kind
  logic                   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  // write_valid, luma_offset, luma_pair, chroma_offset, chroma_next_row, zero fill
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;

  pixel_write_board board = new();
  int gap_pct, stall_pct, hold_left, items_sent;

  yuv420sp_line_rasterizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // Monitor: score results first, then log the input taken at the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_write(m_axis_tdata, m_axis_tlast);
      if (s_axis_tvalid && s_axis_tready) board.note_item(s_axis_tuser, s_axis_tdata);
    end
  end

  // Result side: random stalls, or a counted hold-off when one is requested
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Offer one transaction, with random idle cycles ahead of it
  task automatic offer(logic kind, logic [IN_TDATA_W-1:0] data);
    while ($urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= data;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [IN_TDATA_W-1:0] rand_payload();
    logic [63:0] v;
    v = {$urandom(), $urandom()};
    return v[IN_TDATA_W-1:0];
  endfunction

  task automatic load_seg(int ax, int ay, int bx, int by);
    offer(KIND_LOAD, {12'(by), 12'(bx), 12'(ay), 12'(ax)});
  endtask

  // Step requests carry junk in tdata; the block must ignore it
  task automatic step_walk(int n);
    repeat (n) offer(KIND_STEP, rand_payload());
  endtask

  function automatic int walk_len(int ax, int ay, int bx, int by);
    int adx, ady;
    adx = (ax > bx) ? ax - bx : bx - ax;
    ady = (ay > by) ? ay - by : by - ay;
    return (adx == 0 || ady >= 3 * adx) ? ady + 1 : adx + 1;
  endfunction

  function automatic int coord_clip(int v);
    return (v < 0) ? 0 : (v > int'(COORD_MAX)) ? int'(COORD_MAX) : v;
  endfunction

  // Stop offering input and wait until every owed write has left
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (board.pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    board.set_reg(idx, CFG_DATA_W'(val));
    @(negedge clk_i);
  endtask

  task automatic apply_config(int w, int h, int ls, int cs, int yl, int cb, int cr);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_LUMA_STRIDE, ls);
    write_reg(REG_CHROMA_STRIDE, cs);
    write_reg(REG_DRAW_LUMA, yl);
    write_reg(REG_DRAW_CB, cb);
    write_reg(REG_DRAW_CR, cr);
    // unmapped index must change nothing
    write_reg(REG_UNMAPPED, $urandom_range(8191));
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Mostly whole segment walks with random geometry; some cut short, some
  // overrun into idle steps, and a share of stray transactions
  task automatic random_walks(int n);
    int target, span, len, ax, ay, bx, by;
    target = items_sent + n;
    while (items_sent < target) begin
      if ($urandom_range(99) < 85) begin
        span = ($urandom_range(29) == 0) ? 160 : 12;
        if ($urandom_range(1)) begin
          ax = $urandom_range(COORD_MAX);
          ay = $urandom_range(COORD_MAX);
        end else begin
          ax = $urandom_range(board.img_w);
          ay = $urandom_range(board.img_h);
        end
        bx = coord_clip(ax + int'($urandom_range(2 * span)) - span);
        by = coord_clip(ay + int'($urandom_range(2 * span)) - span);
        load_seg(ax, ay, bx, by);
        len = walk_len(ax, ay, bx, by);
        if ($urandom_range(6) == 0) len = $urandom_range(len);
        else if ($urandom_range(9) == 0) len += $urandom_range(2, 1);
        step_walk(len);
      end else begin
        offer(logic'($urandom_range(1)), rand_payload());
      end
    end
  endtask

  // Timeout guard
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = KIND_LOAD;
    gap_pct = 0;
    stall_pct = 0;
    hold_left = 0;
    items_sent = 0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, reset configuration
    step_walk(1);                        // step with no segment loaded
    load_seg(10, 20, 10, 23);            // vertical
    step_walk(4);
    load_seg(100, 50, 101, 53);          // |dy| == 3|dx|, steep
    step_walk(2);
    load_seg(1919, 1079, 1917, 1079);    // horizontal: starts at B, ends on last column
    step_walk(3);
    load_seg(5, 0, 2, 2);                // flat, walking toward smaller x
    step_walk(4);
    step_walk(1);                        // past the end of the segment
    load_seg(1919, 0, 1919, 1);          // steep on the last column: no pair
    step_walk(2);
    load_seg(4095, 4095, 0, 0);          // extreme corners; the walk starts at B, inside the image
    step_walk(1);
    load_seg(4095, 0, 0, 4095);          // replaces the walk above
    step_walk(2);

    // Phase 0: no idling, plus a long hold-off on the result side
    drain();
    hold_left = 200;
    random_walks(420);

    // Phase 1: largest registers, sender idling
    drain();
    apply_config(4095, 4095, 8191, 8191, 255, 0, 128);
    gap_pct = 59;
    random_walks(450);

    // Phase 2: receiver stalling; zero-size image first, then a small one
    drain();
    apply_config(0, 0, 0, 0, 0, 255, 0);
    gap_pct = 0;
    stall_pct = 59;
    random_walks(60);
    drain();
    apply_config($urandom_range(200, 1), $urandom_range(200, 1), $urandom_range(8191),
                 $urandom_range(8191), $urandom_range(255), $urandom_range(255),
                 $urandom_range(255));
    random_walks(380);

    // Phase 3: both sides idling, a fresh random setting per round
    gap_pct = 26;
    stall_pct = 26;
    repeat (3) begin
      drain();
      apply_config($urandom_range(4095), $urandom_range(4095), $urandom_range(8191),
                   $urandom_range(8191), $urandom_range(255), $urandom_range(255),
                   $urandom_range(255));
      random_walks(170);
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Run covered %0d input transactions, %0d segment loads and %0d pixel writes",
             items_sent, board.loads, board.results);
    $display("(%0d writes inside the image) across seven register settings and four idle mixes",
             board.inside_writes);
    if (board.errors == 0 && board.pending_writes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ylr_pkg.sv
rtl/ylr_cfg_regs.sv
rtl/ylr_ctrl.sv
rtl/ylr_datapath.sv
rtl/yuv420sp_line_rasterizer_unit.sv
bench/tb_yuv420sp_line_rasterizer_unit.sv
